@@ rtl/otsa_pkg.sv @@
package otsa_pkg;

   // Default sizes of the slot table.
   localparam int SLOT_COUNT_DEF = 1024;
   localparam int OWNER_BITS_DEF = 16;

   // Occupancy is kept as rows of this many bits, one bit per slot.
   localparam int ROW_W = 32;

   // Field widths that do not follow from the table size.
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int CAP_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_ENABLED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY      = CSR_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_RESERVE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK           = 3'd0,
      STS_DISABLED     = 3'd1,
      STS_BAD_OWNER    = 3'd2,
      STS_BAD_SLOT     = 3'd3,
      STS_FULL         = 3'd4,
      STS_ALREADY_FREE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic load_live;
      logic load_hold;
   } cmd_type;

endpackage

@@ rtl/otsa_if.sv @@
// Request channel: one operation on the slot table.
interface otsa_req_if #(
   parameter int SLOT_W  = $clog2(otsa_pkg::SLOT_COUNT_DEF + 1),
   parameter int OWNER_W = otsa_pkg::OWNER_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [otsa_pkg::OP_W-1:0] op;
   logic [OWNER_W-1:0]        owner_id;
   logic [SLOT_W-1:0]         slot_number;

   modport source (output valid, op, owner_id, slot_number, input ready);
   modport sink   (input valid, op, owner_id, slot_number, output ready);
endinterface

// Response channel: outcome of one request.
interface otsa_rsp_if #(
   parameter int SLOT_W  = $clog2(otsa_pkg::SLOT_COUNT_DEF + 1),
   parameter int OWNER_W = otsa_pkg::OWNER_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [otsa_pkg::STATUS_W-1:0] status;
   logic [SLOT_W-1:0]             granted_slot;
   logic [OWNER_W-1:0]            slot_owner;
   logic [SLOT_W-1:0]             free_count;
   logic [SLOT_W-1:0]             occupied_count_out;

   modport source (output valid, status, granted_slot, slot_owner, free_count,
                   occupied_count_out, input ready);
   modport sink   (input valid, status, granted_slot, slot_owner, free_count,
                   occupied_count_out, output ready);
endinterface

// Configuration write channel.
interface otsa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [otsa_pkg::CSR_IDX_W-1:0] index;
   logic [otsa_pkg::CAP_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/otsa_ctrl.sv @@
module otsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output otsa_pkg::cmd_type cmd
);

   otsa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and response-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= otsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         otsa_pkg::ST_IDLE: begin
            // No request is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = otsa_pkg::ST_EXEC;
            end
         end
         otsa_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_live = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = otsa_pkg::ST_IDLE;
            end else begin
               state_in = otsa_pkg::ST_HOLD;
            end
         end
         otsa_pkg::ST_HOLD: begin
            // The finished result waits here until the output register drains.
            if (rsp_ready) begin
               cmd.load_hold = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = otsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = otsa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // An accepted request is always resolved in the following cycle.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == otsa_pkg::ST_EXEC)
      else $error("accepted request did not move to execute");

   // A result is parked only while the output register is occupied.
   a_hold_has_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == otsa_pkg::ST_HOLD |-> rsp_valid_ff)
      else $error("holding a result with an empty output register");

   // The output register is never overwritten before it is taken.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_live || cmd.load_hold) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while still valid");
`endif

endmodule

@@ rtl/otsa_dp.sv @@
module otsa_dp #(
   parameter int SLOT_COUNT = otsa_pkg::SLOT_COUNT_DEF,
   parameter int OWNER_BITS = otsa_pkg::OWNER_BITS_DEF,
   localparam int SLOT_W    = $clog2(SLOT_COUNT + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  otsa_pkg::cmd_type                 cmd,
   input  logic [otsa_pkg::OP_W-1:0]         req_op,
   input  logic [OWNER_BITS-1:0]             req_owner_id,
   input  logic [SLOT_W-1:0]                 req_slot_number,
   input  logic                              csr_we,
   input  logic [otsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [otsa_pkg::CAP_W-1:0]        csr_data,
   output logic [otsa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [SLOT_W-1:0]                 rsp_granted_slot,
   output logic [OWNER_BITS-1:0]             rsp_slot_owner,
   output logic [SLOT_W-1:0]                 rsp_free_count,
   output logic [SLOT_W-1:0]                 rsp_occupied_count_out
);

   localparam int ROW_W   = otsa_pkg::ROW_W;
   localparam int ROWS    = (SLOT_COUNT + ROW_W - 1) / ROW_W;
   localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_AW  = $clog2(ROW_W);
   localparam int IDX_W   = ROW_AW + BIT_AW;
   localparam int SLOT_AW = $clog2(SLOT_COUNT);
   localparam int CMP_W   = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

   // Configuration and table state.
   logic                          enabled_ff;
   logic [otsa_pkg::CAP_W-1:0]    capacity_ff;
   logic [SLOT_W-1:0]             count_ff, count_in;
   logic [ROWS-1:0]               row_valid_ff;
   logic [ROWS-1:0]               row_full_ff;
   logic [SLOT_W-1:0]             cap_eff;

   logic [ROW_W-1:0]              bitmap_mem [ROWS];
   logic [OWNER_BITS-1:0]         owner_mem  [SLOT_COUNT];

   // Request captured at accept, with the memory reads it started.
   logic [otsa_pkg::OP_W-1:0]     op_ff;
   logic [OWNER_BITS-1:0]         owner_ff;
   logic [SLOT_W-1:0]             slot_ff;
   logic [ROW_AW-1:0]             row_sel_ff;
   logic                          any_free_ff;
   logic [ROW_W-1:0]              bm_rd_ff;
   logic                          rv_ff;
   logic [OWNER_BITS-1:0]         own_rd_ff;

   // Accept-cycle signals.
   logic [ROW_AW-1:0]             first_row;
   logic                          first_found;
   logic [SLOT_W-1:0]             req_slot_m1;
   logic [IDX_W-1:0]              req_idx;
   logic [ROW_AW-1:0]             rd_row;

   // Execute-cycle signals.
   logic [ROW_W-1:0]              row_data;
   logic [BIT_AW-1:0]             fbit;
   logic                          fbit_found;
   logic [IDX_W-1:0]              cand_idx;
   logic [SLOT_W-1:0]             slot_m1;
   logic [IDX_W-1:0]              slot_idx;
   logic [BIT_AW-1:0]             slot_bit;
   logic                          slot_bad;
   logic                          slot_held;
   logic                          bm_we;
   logic [ROW_W-1:0]              bm_wdata;
   logic                          own_we;
   logic [otsa_pkg::STATUS_W-1:0] live_status;
   logic [SLOT_W-1:0]             live_granted;
   logic [OWNER_BITS-1:0]         live_owner;
   logic [SLOT_W-1:0]             live_free;
   logic [SLOT_W-1:0]             live_occ;

   // Held and output result registers.
   logic [otsa_pkg::STATUS_W-1:0] hold_status_ff, out_status_ff;
   logic [SLOT_W-1:0]             hold_granted_ff, out_granted_ff;
   logic [OWNER_BITS-1:0]         hold_owner_ff, out_owner_ff;
   logic [SLOT_W-1:0]             hold_free_ff, out_free_ff;
   logic [SLOT_W-1:0]             hold_occ_ff, out_occ_ff;

   // Capacity above the table size saturates to the table size.
   always_comb begin
      if (32'(capacity_ff) > 32'(SLOT_COUNT)) begin
         cap_eff = SLOT_W'(SLOT_COUNT);
      end else begin
         cap_eff = SLOT_W'(capacity_ff);
      end
   end

   // Lowest row that still has a free slot.
   always_comb begin
      first_row   = '0;
      first_found = 1'b0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!row_full_ff[r]) begin
            first_row   = ROW_AW'(r);
            first_found = 1'b1;
         end
      end
   end

   // Row to read: the first non-full row for reserve, else the addressed slot's row.
   always_comb begin
      req_slot_m1 = req_slot_number - SLOT_W'(1);
      req_idx     = IDX_W'(req_slot_m1);
      if (req_op == otsa_pkg::OP_RESERVE) begin
         rd_row = first_row;
      end else begin
         rd_row = req_idx[IDX_W-1:BIT_AW];
      end
   end

   // Capture the request and read both memories.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_op;
         owner_ff    <= req_owner_id;
         slot_ff     <= req_slot_number;
         row_sel_ff  <= rd_row;
         any_free_ff <= first_found;
         bm_rd_ff    <= bitmap_mem[rd_row];
         rv_ff       <= row_valid_ff[rd_row];
         own_rd_ff   <= owner_mem[req_idx[SLOT_AW-1:0]];
      end
   end

   // A row never written since the last clear reads as all free.
   assign row_data = rv_ff ? bm_rd_ff : '0;

   // Lowest free bit in the selected row.
   always_comb begin
      fbit       = '0;
      fbit_found = 1'b0;
      for (int b = ROW_W - 1; b >= 0; b--) begin
         if (!row_data[b]) begin
            fbit       = BIT_AW'(b);
            fbit_found = 1'b1;
         end
      end
   end

   assign cand_idx  = {row_sel_ff, fbit};
   assign slot_m1   = slot_ff - SLOT_W'(1);
   assign slot_idx  = IDX_W'(slot_m1);
   assign slot_bit  = slot_idx[BIT_AW-1:0];
   assign slot_bad  = (slot_ff == '0) || (slot_ff > cap_eff);
   assign slot_held = row_data[slot_bit];

   // Resolve the operation and work out the write-back.
   always_comb begin
      live_status  = otsa_pkg::STS_OK;
      live_granted = '0;
      live_owner   = '0;
      count_in     = count_ff;
      bm_we        = 1'b0;
      bm_wdata     = row_data;
      own_we       = 1'b0;
      if (!enabled_ff) begin
         live_status = otsa_pkg::STS_DISABLED;
      end else begin
         unique case (op_ff)
            otsa_pkg::OP_RESERVE: begin
               if (owner_ff == '0) begin
                  live_status = otsa_pkg::STS_BAD_OWNER;
               end else if (any_free_ff && fbit_found &&
                            (CMP_W'(cand_idx) < CMP_W'(cap_eff))) begin
                  live_granted = SLOT_W'(CMP_W'(cand_idx) + CMP_W'(1));
                  bm_we        = 1'b1;
                  bm_wdata     = row_data | (ROW_W'(1) << fbit);
                  own_we       = 1'b1;
                  count_in     = count_ff + SLOT_W'(1);
               end else begin
                  live_status = otsa_pkg::STS_FULL;
               end
            end
            otsa_pkg::OP_RELEASE, otsa_pkg::OP_QUERY: begin
               if (slot_bad) begin
                  live_status = otsa_pkg::STS_BAD_SLOT;
               end else begin
                  live_owner = slot_held ? own_rd_ff : '0;
                  if (op_ff == otsa_pkg::OP_RELEASE) begin
                     if (!slot_held) begin
                        live_status = otsa_pkg::STS_ALREADY_FREE;
                     end else begin
                        bm_we    = 1'b1;
                        bm_wdata = row_data & ~(ROW_W'(1) << slot_bit);
                        if (count_ff != '0) begin
                           count_in = count_ff - SLOT_W'(1);
                        end
                     end
                  end
               end
            end
            default: begin
               // Unused operation code: nothing changes.
            end
         endcase
      end
   end

   // Counts reported with the result.
   always_comb begin
      if (!enabled_ff) begin
         live_free = '0;
         live_occ  = '0;
      end else begin
         live_free = (cap_eff >= count_in) ? cap_eff - count_in : '0;
         live_occ  = count_in;
      end
   end

   // Configuration, occupancy count and row flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         capacity_ff  <= otsa_pkg::CAP_RESET;
         count_ff     <= '0;
         row_valid_ff <= '0;
         row_full_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            otsa_pkg::REG_TABLE_ENABLED: begin
               enabled_ff <= csr_data[0];
               if (!csr_data[0]) begin
                  count_ff     <= '0;
                  row_valid_ff <= '0;
                  row_full_ff  <= '0;
               end
            end
            otsa_pkg::REG_CAPACITY: begin
               // A new capacity starts the table over.
               capacity_ff  <= csr_data;
               count_ff     <= '0;
               row_valid_ff <= '0;
               row_full_ff  <= '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.exec) begin
         count_ff <= count_in;
         if (bm_we) begin
            row_valid_ff[row_sel_ff] <= 1'b1;
            row_full_ff[row_sel_ff]  <= &bm_wdata;
         end
      end
   end

   // Memory write-back.
   always_ff @(posedge clock) begin
      if (cmd.exec && bm_we) begin
         bitmap_mem[row_sel_ff] <= bm_wdata;
      end
      if (cmd.exec && own_we) begin
         owner_mem[cand_idx[SLOT_AW-1:0]] <= owner_ff;
      end
   end

   // Result staging: parked copy and output register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hold_status_ff  <= live_status;
         hold_granted_ff <= live_granted;
         hold_owner_ff   <= live_owner;
         hold_free_ff    <= live_free;
         hold_occ_ff     <= live_occ;
      end
      if (cmd.load_live) begin
         out_status_ff  <= live_status;
         out_granted_ff <= live_granted;
         out_owner_ff   <= live_owner;
         out_free_ff    <= live_free;
         out_occ_ff     <= live_occ;
      end else if (cmd.load_hold) begin
         out_status_ff  <= hold_status_ff;
         out_granted_ff <= hold_granted_ff;
         out_owner_ff   <= hold_owner_ff;
         out_free_ff    <= hold_free_ff;
         out_occ_ff     <= hold_occ_ff;
      end
   end

   assign rsp_status             = out_status_ff;
   assign rsp_granted_slot       = out_granted_ff;
   assign rsp_slot_owner         = out_owner_ff;
   assign rsp_free_count         = out_free_ff;
   assign rsp_occupied_count_out = out_occ_ff;

`ifndef NO_ASSERTIONS
   // Occupancy never exceeds the usable capacity.
   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(cap_eff))
      else $error("occupied count exceeds capacity");

   // A row can only be marked full after it has been written.
   a_full_implies_valid: assert property (@(posedge clock) disable iff (reset)
      (row_full_ff & ~row_valid_ff) == '0)
      else $error("row marked full without valid contents");

   // A granted slot adds exactly one to the occupancy.
   a_grant_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && own_we) |=> count_ff == SLOT_W'($past(count_ff) + SLOT_W'(1)))
      else $error("reserve did not increment the occupied count");
`endif

endmodule

@@ rtl/owner_tagged_slot_allocator_unit.sv @@
// Owner-tagged slot allocator. Each request reserves the lowest free slot
// among slots 1..capacity for an owner, releases a slot and returns its
// owner, or queries a slot's owner; every response also carries the free
// and occupied counts. In the accept cycle the lowest non-full occupancy
// row is picked from the per-row full flags and the occupancy row and
// owner memories are read; in the next cycle the row is searched for its
// lowest free bit and the memories are written back. One request is in
// flight at a time, so a new request is accepted only after the last one
// has been resolved. A response that is not taken waits in the output
// register while the next request is accepted and resolved; that second
// result is parked until the output register drains. Reset, disabling
// the table and writing a new capacity clear the table at once through
// per-row valid flags, with no clearing pass. The configuration port is
// ready in every cycle outside reset; the user must write it only while
// no request is outstanding, as the block itself does not enforce this.
module owner_tagged_slot_allocator_unit #(
   parameter int SLOT_COUNT = otsa_pkg::SLOT_COUNT_DEF,
   parameter int OWNER_BITS = otsa_pkg::OWNER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   otsa_req_if.sink   req_ch,
   otsa_rsp_if.source rsp_ch,
   otsa_csr_if.sink   csr_ch
);

   otsa_pkg::cmd_type cmd;

   // The configuration registers accept a write in every cycle outside reset.
   assign csr_ch.ready = !reset;

   otsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   otsa_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .OWNER_BITS (OWNER_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_op                 (req_ch.op),
      .req_owner_id           (req_ch.owner_id),
      .req_slot_number        (req_ch.slot_number),
      .csr_we                 (csr_ch.valid),
      .csr_index              (csr_ch.index),
      .csr_data               (csr_ch.data),
      .rsp_status             (rsp_ch.status),
      .rsp_granted_slot       (rsp_ch.granted_slot),
      .rsp_slot_owner         (rsp_ch.slot_owner),
      .rsp_free_count         (rsp_ch.free_count),
      .rsp_occupied_count_out (rsp_ch.occupied_count_out)
   );

endmodule
